@@ design/bsc_pkg.sv @@
// Shared types and register map of the barometric sensor compensation block.
package bsc_pkg;

  typedef struct packed {
    logic signed [23:0] raw_temp;
    logic signed [23:0] raw_press;
  } bsc_in_t;

  typedef struct packed {
    logic signed [31:0] press_out;
    logic signed [31:0] temp_out;
  } bsc_out_t;

  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;

  // register index, taken from paddr[5:3]
  localparam logic [2:0] REG_COEF_FIRST  = 3'd0;
  localparam logic [2:0] REG_COEF_MIDDLE = 3'd1;
  localparam logic [2:0] REG_COEF_LAST   = 3'd2;
  localparam logic [2:0] REG_TEMP_SCALE  = 3'd3;
  localparam logic [2:0] REG_PRESS_SCALE = 3'd4;

  localparam logic [23:0] SCALE_RESET = 24'd524288;

endpackage

@@ design/bsc_dly.sv @@
// Enabled shift line used to align operands and valid bits across the pipeline.
module bsc_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) pipe_q[i] <= '0;
    end else if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < N; i++) pipe_q[i] <= pipe_q[i-1];
    end
  end

  assign q_o = pipe_q[N-1];

endmodule

@@ design/bsc_div.sv @@
// Pipelined restoring divider: raw reading over scale into Q.F, round half up.
module bsc_div #(
  parameter int unsigned FRAC = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [23:0] raw_i,
  input  logic        [23:0] scale_i,
  output logic signed [63:0] quo_o
);

  localparam int unsigned NUMW = FRAC + 26;
  localparam int unsigned NMW  = FRAC + 25;

  logic [23:0]            scale_eff;
  logic [24:0]            den;
  logic signed [NUMW-1:0] num;
  logic [NUMW-1:0]        num_neg;
  logic [NMW-1:0]         mag;

  logic [NMW-1:0] work_q [NMW+1];
  logic [24:0]    rem_q  [NMW+1];
  logic           neg_q  [NMW+1];
  logic [63:0]    qu;
  logic [63:0]    adj;
  logic [63:0]    quo_q;

  assign scale_eff = (scale_i == 24'd0) ? 24'd1 : scale_i;
  assign den       = {scale_eff, 1'b0};

  // raw * 2^(F+1) + d, over 2d gives floor(raw * 2^F / d + 1/2)
  assign num     = $signed({raw_i[23], raw_i, {(FRAC + 1){1'b0}}})
                 + $signed({{(NUMW - 24){1'b0}}, scale_eff});
  assign num_neg = -num;
  assign mag     = num[NUMW-1] ? num_neg[NMW-1:0] : num[NMW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      work_q[0] <= mag;
      rem_q[0]  <= '0;
      neg_q[0]  <= num[NUMW-1];
    end
  end

  for (genvar i = 0; i < NMW; i++) begin : g_step
    logic [25:0] part;
    logic [25:0] trial;
    assign part  = {rem_q[i], work_q[i][NMW-1]};
    assign trial = part - {1'b0, den};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1]  <= trial[25] ? part[24:0] : trial[24:0];
        work_q[i+1] <= {work_q[i][NMW-2:0], ~trial[25]};
        neg_q[i+1]  <= neg_q[i];
      end
    end
  end

  // negative numerators: floor is minus the ceiling of the magnitude quotient
  assign qu  = 64'(work_q[NMW]);
  assign adj = qu + 64'(rem_q[NMW] != 25'd0);

  always_ff @(posedge clk_i) begin
    if (en_i) quo_q <= neg_q[NMW] ? -adj : qu;
  end

  assign quo_o = $signed(quo_q);

endmodule

@@ design/bsc_qmul.sv @@
// Six-stage Q.F multiplier: 32x32 partial products, round half up, saturate to 64 bits.
module bsc_qmul #(
  parameter int unsigned FRAC = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic signed [63:0] p_o
);

  localparam logic [127:0] HALF = 128'(1) << (FRAC - 1);

  logic [63:0]  ua_q, ub_q;
  logic         neg1_q, neg2_q, neg3_q;
  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [127:0] mag_q;
  logic [127:0] sv_q;
  logic [127:0] rnd_q;
  logic [63:0]  p_q;
  logic [127:0] mag_d;
  logic [64-FRAC:0] top;
  logic         fits;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q   <= a_i[63] ? -a_i : a_i;
      ub_q   <= b_i[63] ? -b_i : b_i;
      neg1_q <= a_i[63] ^ b_i[63];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q  <= ua_q[31:0]  * ub_q[31:0];
      p01_q  <= ua_q[31:0]  * ub_q[63:32];
      p10_q  <= ua_q[63:32] * ub_q[31:0];
      p11_q  <= ua_q[63:32] * ub_q[63:32];
      neg2_q <= neg1_q;
    end
  end

  assign mag_d = {p11_q, p00_q} + ({64'd0, p01_q} << 32) + ({64'd0, p10_q} << 32);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      neg3_q <= neg2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) sv_q <= neg3_q ? -mag_q : mag_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rnd_q <= sv_q + HALF;
  end

  // bits above the shifted 64-bit window must all match the sign
  assign top  = rnd_q[127:FRAC+63];
  assign fits = (&top) | ~(|top);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (fits)          p_q <= rnd_q[FRAC+63:FRAC];
      else if (rnd_q[127]) p_q <= {1'b1, 63'd0};
      else               p_q <= {1'b0, {63{1'b1}}};
    end
  end

  assign p_o = $signed(p_q);

endmodule

@@ design/baro_sensor_compensation.sv @@
// Top level: config registers, scaling dividers and the polynomial pipeline.
//
//   channel | direction | handshake            | payload
//   in      | request   | in_valid_i/in_stall_o | bsc_in_t  raw_temp, raw_press
//   out     | result    | out_valid_o/out_stall_i | bsc_out_t press_out, temp_out
//   cfg     | APB       | psel/penable/pready  | 64-bit registers at 8*index
//
// One request per cycle unless the output stalls; pipeline depth is set by the
// bit-per-stage dividers and the chain of three multiplies in the pressure polynomial.
// Reset clears valid bits and coefficient registers; scales reset to 524288.
// A stalled result freezes the whole pipeline; bubbles are kept, nothing is lost.
module baro_sensor_compensation #(
  parameter int unsigned SCALED_FRAC_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  bsc_pkg::bsc_in_t        in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output bsc_pkg::bsc_out_t       out_data_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [bsc_pkg::ADDR_W-1:0] paddr,
  input  logic [bsc_pkg::DATA_W-1:0] pwdata,
  output logic [bsc_pkg::DATA_W-1:0] prdata,
  output logic                    pready
);

  import bsc_pkg::*;

  localparam int unsigned F       = SCALED_FRAC_BITS;
  localparam int unsigned LATENCY = F + 52;
  localparam int unsigned SP      = F - 6;
  localparam int unsigned ST      = F - 8;
  localparam logic signed [63:0] HALF_P = 64'sd1 <<< (SP - 1);
  localparam logic signed [63:0] HALF_T = 64'sd1 <<< (ST - 1);

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if ((&v[63:31]) | ~(|v[63:31])) return v[31:0];
    return v[63] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
  endfunction

  // configuration
  logic [63:0] coef_first_q, coef_middle_q;
  logic [15:0] coef_last_q;
  logic [23:0] temp_scale_q, press_scale_q;
  logic [2:0]  reg_idx;

  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_first_q  <= '0;
      coef_middle_q <= '0;
      coef_last_q   <= '0;
      temp_scale_q  <= SCALE_RESET;
      press_scale_q <= SCALE_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_COEF_FIRST:  coef_first_q  <= pwdata;
        REG_COEF_MIDDLE: coef_middle_q <= pwdata;
        REG_COEF_LAST:   coef_last_q   <= pwdata[15:0];
        REG_TEMP_SCALE:  temp_scale_q  <= pwdata[23:0];
        REG_PRESS_SCALE: press_scale_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COEF_FIRST:  prdata = coef_first_q;
      REG_COEF_MIDDLE: prdata = coef_middle_q;
      REG_COEF_LAST:   prdata = {48'd0, coef_last_q};
      REG_TEMP_SCALE:  prdata = {40'd0, temp_scale_q};
      REG_PRESS_SCALE: prdata = {40'd0, press_scale_q};
      default:         prdata = '0;
    endcase
  end

  // coefficients in Q.F
  logic signed [63:0] c0h, c1q, c00q, c10q, c01q, c11q, c20q, c21q, c30q;

  assign c0h  = $signed({{52{coef_first_q[63]}}, coef_first_q[63:52]}) <<< (F - 1);
  assign c1q  = $signed({{52{coef_first_q[51]}}, coef_first_q[51:40]}) <<< F;
  assign c00q = $signed({{44{coef_first_q[39]}}, coef_first_q[39:20]}) <<< F;
  assign c10q = $signed({{44{coef_first_q[19]}}, coef_first_q[19:0]}) <<< F;
  assign c01q = $signed({{48{coef_middle_q[63]}}, coef_middle_q[63:48]}) <<< F;
  assign c11q = $signed({{48{coef_middle_q[47]}}, coef_middle_q[47:32]}) <<< F;
  assign c20q = $signed({{48{coef_middle_q[31]}}, coef_middle_q[31:16]}) <<< F;
  assign c21q = $signed({{48{coef_middle_q[15]}}, coef_middle_q[15:0]}) <<< F;
  assign c30q = $signed({{48{coef_last_q[15]}}, coef_last_q}) <<< F;

  // flow control: the whole pipe advances unless a result is held
  logic en;
  logic accept;
  logic valid_out;

  assign in_stall_o  = valid_out & out_stall_i;
  assign en          = ~in_stall_o;
  assign accept      = in_valid_i & en;
  assign out_valid_o = valid_out;

  bsc_dly #(.W(1), .N(LATENCY)) u_valid (
    .clk_i, .rst_ni, .en_i(en), .d_i(accept), .q_o(valid_out)
  );

  // scaling
  logic signed [63:0] ts, ps;

  bsc_div #(.FRAC(F)) u_div_t (
    .clk_i, .en_i(en), .raw_i(in_data_i.raw_temp), .scale_i(temp_scale_q), .quo_o(ts)
  );
  bsc_div #(.FRAC(F)) u_div_p (
    .clk_i, .en_i(en), .raw_i(in_data_i.raw_press), .scale_i(press_scale_q), .quo_o(ps)
  );

  // polynomial; stage numbers count from the divider output
  logic signed [63:0] m1, m2, m3, m4, m5, m6, m7, m8;
  logic [63:0]        ps7, ps14, ts15, m6d, m7d, t1d;
  logic signed [63:0] a1_q, a2_q, p1_q, p2_q, b_q, p_q, t1_q, pr_q, tr_q;
  bsc_out_t           out_q;

  bsc_dly #(.W(64), .N(7))  u_ps7  (.clk_i, .rst_ni, .en_i(en), .d_i(ps), .q_o(ps7));
  bsc_dly #(.W(64), .N(7))  u_ps14 (.clk_i, .rst_ni, .en_i(en), .d_i(ps7), .q_o(ps14));
  bsc_dly #(.W(64), .N(15)) u_ts15 (.clk_i, .rst_ni, .en_i(en), .d_i(ts), .q_o(ts15));
  bsc_dly #(.W(64), .N(1))  u_m6d  (.clk_i, .rst_ni, .en_i(en), .d_i(m6), .q_o(m6d));
  bsc_dly #(.W(64), .N(9))  u_m7d  (.clk_i, .rst_ni, .en_i(en), .d_i(m7), .q_o(m7d));
  bsc_dly #(.W(64), .N(16)) u_t1d  (.clk_i, .rst_ni, .en_i(en), .d_i(t1_q), .q_o(t1d));

  bsc_qmul #(.FRAC(F)) u_m1 (.clk_i, .en_i(en), .a_i(ps), .b_i(c30q), .p_o(m1));
  bsc_qmul #(.FRAC(F)) u_m2 (.clk_i, .en_i(en), .a_i($signed(ps7)), .b_i(a1_q), .p_o(m2));
  bsc_qmul #(.FRAC(F)) u_m3 (.clk_i, .en_i(en), .a_i($signed(ps14)), .b_i(a2_q), .p_o(m3));
  bsc_qmul #(.FRAC(F)) u_m4 (.clk_i, .en_i(en), .a_i($signed(ts15)), .b_i(c01q), .p_o(m4));
  bsc_qmul #(.FRAC(F)) u_m5 (.clk_i, .en_i(en), .a_i(ps), .b_i(c21q), .p_o(m5));
  bsc_qmul #(.FRAC(F)) u_m6 (.clk_i, .en_i(en), .a_i(ts), .b_i(ps), .p_o(m6));
  bsc_qmul #(.FRAC(F)) u_m7 (.clk_i, .en_i(en), .a_i($signed(m6d)), .b_i(b_q), .p_o(m7));
  bsc_qmul #(.FRAC(F)) u_m8 (.clk_i, .en_i(en), .a_i(c1q), .b_i(ts), .p_o(m8));

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q <= sat_add(c20q, m1);               // stage 7
      b_q  <= sat_add(c11q, m5);               // stage 7
      t1_q <= sat_add(c0h, m8);                // stage 7
      a2_q <= sat_add(c10q, m2);               // stage 14
      p1_q <= sat_add(c00q, m3);               // stage 21
      p2_q <= sat_add(p1_q, m4);               // stage 22
      p_q  <= sat_add(p2_q, $signed(m7d));     // stage 23
      pr_q <= sat_add(p_q, HALF_P);            // stage 24
      tr_q <= sat_add($signed(t1d), HALF_T);   // stage 24
      out_q.press_out <= clamp32(pr_q >>> SP);
      out_q.temp_out  <= clamp32(tr_q >>> ST);
    end
  end

  assign out_data_o = out_q;

endmodule
